[sv/gmc_pkg.sv]
`default_nettype none

package gmc_pkg;

  // Width of the event and result payloads on the stream ports
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned InTuserW  = 1;
  localparam int unsigned OutTdataW = 8;

  // Event kinds carried in tuser
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_PORT   = 1'b1;

  // Heading codes
  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_BACK    = 1'b1;

  typedef struct packed {
    logic power_on;
    logic torque_flag;
    logic must_close;
    logic direction;
    logic bwd_drive;
    logic fwd_drive;
  } gmc_state_t;

  typedef struct packed {
    logic running_sensor;
    logic overtorque_seen;
    logic beam_blocked;
    logic opened_sensor;
    logic closed_sensor;
    logic opcode;
  } gmc_event_t;

  // Members are listed from out_tdata bit 6 downward to bit 0
  typedef struct packed {
    logic heading;
    logic restart_idle_timer;
    logic rollback_pulse;
    logic overtorque_latched;
    logic motor_power;
    logic drive_backward;
    logic drive_forward;
  } gmc_result_t;

  localparam gmc_state_t STATE_RESET = '{
    power_on:    1'b0,
    torque_flag: 1'b0,
    must_close:  1'b0,
    direction:   DIR_FORWARD,
    bwd_drive:   1'b0,
    fwd_drive:   1'b0
  };

endpackage

`default_nettype wire

[sv/gmc_step.sv]
`default_nettype none

// Next-state and result logic for one gate event.
module gmc_step
  import gmc_pkg::*;
(
  input  gmc_event_t  ev,
  input  gmc_state_t  st,
  output gmc_state_t  st_nxt,
  output gmc_result_t res
);

  gmc_state_t s;
  logic       pulse;
  logic       reload;

  always_comb begin
    s      = st;
    pulse  = 1'b0;
    reload = 1'b0;

    if (ev.opcode == OP_BUTTON) begin
      reload = 1'b1;
      if (ev.closed_sensor && ev.opened_sensor) begin
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
      end else if (st.fwd_drive || st.bwd_drive) begin
        // stop and turn around
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
        s.direction = ~st.direction;
      end else if (st.direction == DIR_FORWARD) begin
        if (!ev.closed_sensor) begin
          s.bwd_drive = 1'b0;
          if (!ev.beam_blocked) begin
            s.direction = DIR_FORWARD;
            s.fwd_drive = 1'b1;
          end
        end else begin
          s.fwd_drive = 1'b0;
          s.direction = DIR_BACK;
          s.bwd_drive = 1'b1;
        end
      end else begin
        if (!ev.opened_sensor) begin
          s.fwd_drive = 1'b0;
          s.direction = DIR_BACK;
          s.bwd_drive = 1'b1;
        end else begin
          s.bwd_drive = 1'b0;
          if (!ev.beam_blocked) begin
            s.direction = DIR_FORWARD;
            s.fwd_drive = 1'b1;
          end else begin
            s.fwd_drive = 1'b0;
          end
        end
      end
      s.torque_flag = 1'b0;
      s.must_close  = 1'b0;
      s.power_on    = 1'b1;
    end else begin
      // beam break while closing: reverse to open
      if (ev.beam_blocked && s.fwd_drive && !s.must_close) begin
        s.fwd_drive = 1'b0;
        s.direction = DIR_BACK;
        s.bwd_drive = 1'b1;
      end
      if (ev.overtorque_seen) begin
        s.must_close = 1'b0;
        if (s.direction == DIR_FORWARD) begin
          if (ev.opened_sensor) begin
            s.fwd_drive = 1'b0;
            s.bwd_drive = 1'b0;
          end else if (ev.running_sensor) begin
            s.fwd_drive = 1'b0;
            s.bwd_drive = 1'b0;
            pulse       = 1'b1;
            s.direction = DIR_BACK;
          end
        end else begin
          s.fwd_drive = 1'b0;
          s.bwd_drive = 1'b0;
          s.direction = DIR_FORWARD;
        end
        s.torque_flag = 1'b1;
      end
      if (ev.closed_sensor && ev.opened_sensor) begin
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
      end else if (ev.closed_sensor) begin
        s.fwd_drive  = 1'b0;
        s.direction  = DIR_BACK;
        s.must_close = 1'b1;
        reload       = 1'b1;
      end else if (ev.opened_sensor) begin
        s.bwd_drive = 1'b0;
        s.direction = DIR_FORWARD;
      end else if (s.direction == DIR_BACK && s.must_close && !s.bwd_drive) begin
        // pushed open by hand: close again
        s.power_on  = 1'b1;
        s.fwd_drive = 1'b1;
        s.direction = DIR_FORWARD;
      end
    end
  end

  assign st_nxt                 = s;
  assign res.drive_forward      = s.fwd_drive;
  assign res.drive_backward     = s.bwd_drive;
  assign res.motor_power        = s.power_on;
  assign res.overtorque_latched = s.torque_flag;
  assign res.rollback_pulse     = pulse;
  assign res.restart_idle_timer = reload;
  assign res.heading            = s.direction;

endmodule

`default_nettype wire

[sv/gate_motor_controller_core.sv]
`default_nettype none

// Sliding-gate motor controller core. Each input transfer is one event: a
// button press (in_tuser = 0) or a sensor port change (in_tuser = 1), with the
// closed, opened, infrared-beam, overtorque and running sensor levels in
// in_tdata. Each event yields exactly one result transfer carrying the forward
// and backward drive bits, motor power, the latched overtorque flag, the
// rollback pulse request, the idle-timer reload request and the heading. The
// block takes one event per clock cycle while out_tready stays high. Each
// event passes the input register and then the result register before
// out_tvalid rises. The rate is set by the state update loop: the gate state
// registers are updated by the step logic in the same cycle the result
// register loads, so each event sees the state left by the one before. A
// result waiting on out_tready holds the next event in the input register; a
// further event waits on in_tready until the result drains. While out_tready
// stays high, events flow back to back.
// After reset the drives are off, the heading is forward (closing), and motor
// power is off until the first button press or forced re-close.
module gate_motor_controller_core
  import gmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] closed_sensor, [1] opened_sensor, [2] beam_blocked,
  // [3] overtorque_seen, [4] running_sensor, [7:5] zero
  input  wire logic [InTdataW-1:0]   in_tdata,
  // [0] opcode
  input  wire logic [InTuserW-1:0]   in_tuser,

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] drive_forward, [1] drive_backward, [2] motor_power,
  // [3] overtorque_latched, [4] rollback_pulse, [5] restart_idle_timer,
  // [6] heading, [7] zero
  output logic [OutTdataW-1:0]       out_tdata
);

  localparam int unsigned ResW = $bits(gmc_result_t);

  // Input register
  logic        in_valid_r;
  logic        in_valid_nxt;
  gmc_event_t  ev_r;

  // Gate state
  gmc_state_t  state_r;
  gmc_state_t  state_nxt;

  // Result register
  logic        out_valid_r;
  logic        out_valid_nxt;
  gmc_result_t res_r;
  gmc_result_t res_c;

  logic        in_xfer;
  logic        advance;

  // Advance the event into the result register when that register is free
  // or is being drained this cycle.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  gmc_step u_step (
    .ev     (ev_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_c)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ev_r.opcode          <= in_tuser[0];
      ev_r.closed_sensor   <= in_tdata[0];
      ev_r.opened_sensor   <= in_tdata[1];
      ev_r.beam_blocked    <= in_tdata[2];
      ev_r.overtorque_seen <= in_tdata[3];
      ev_r.running_sensor  <= in_tdata[4];
    end
    if (advance) begin
      res_r <= res_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutTdataW - ResW){1'b0}}, res_r};

endmodule

`default_nettype wire

[sv/gmc_checker.sv]
`default_nettype none

module gmc_checker
  import gmc_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_tvalid,
  input wire logic                 in_tready,
  input wire logic [InTdataW-1:0]  in_tdata,
  input wire logic [InTuserW-1:0]  in_tuser,
  input wire logic                 out_tvalid,
  input wire logic                 out_tready,
  input wire logic [OutTdataW-1:0] out_tdata
);

  // Never drive both directions at once
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("both drive bits set");

  // A running drive implies motor power
  a_drive_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[0] || out_tdata[1])) |-> out_tdata[2])
    else $error("drive active without motor power");

  // Rollback leaves drives off, heading back and the overtorque flag set
  a_rollback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[4]) |->
      (!out_tdata[0] && !out_tdata[1] && out_tdata[3] && out_tdata[6]))
    else $error("rollback result inconsistent");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  // Stalled event holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && !in_tready) |=>
      (in_tvalid && $stable(in_tdata) && $stable(in_tuser)))
    else $error("stalled event changed");

endmodule

bind gate_motor_controller_core gmc_checker u_gmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[verif/gate_motor_checker.sv]
module gate_motor_checker
  import gmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,
  input  logic [InTuserW-1:0]  in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OutTdataW-1:0] out_tdata,
  output int unsigned          fail_count,
  output int unsigned          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  gmc_state_t  gate_st;
  gmc_result_t pending_results[$];

  // Advance the gate state by one event and return the result it reports.
  function automatic gmc_result_t gate_next(input gmc_event_t ev, input gmc_state_t cur,
                                            output gmc_state_t nxt);
    gmc_state_t  s;
    gmc_result_t r;
    s = cur;
    r = '0;
    if (ev.opcode == OP_BUTTON) begin
      if (ev.closed_sensor && ev.opened_sensor) begin
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
      end else if (s.fwd_drive || s.bwd_drive) begin
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
        s.direction = ~s.direction;
      end else if (s.direction == DIR_FORWARD) begin
        if (!ev.closed_sensor) begin
          s.bwd_drive = 1'b0;
          if (!ev.beam_blocked) begin
            s.direction = DIR_FORWARD;
            s.fwd_drive = 1'b1;
          end
        end else begin
          s.fwd_drive = 1'b0;
          s.direction = DIR_BACK;
          s.bwd_drive = 1'b1;
        end
      end else begin
        if (!ev.opened_sensor) begin
          s.fwd_drive = 1'b0;
          s.direction = DIR_BACK;
          s.bwd_drive = 1'b1;
        end else begin
          s.bwd_drive = 1'b0;
          if (!ev.beam_blocked) begin
            s.direction = DIR_FORWARD;
            s.fwd_drive = 1'b1;
          end else begin
            s.fwd_drive = 1'b0;
          end
        end
      end
      s.torque_flag = 1'b0;
      s.must_close = 1'b0;
      s.power_on = 1'b1;
      r.restart_idle_timer = 1'b1;
    end else begin
      // beam break while closing turns the gate back open
      if (ev.beam_blocked && s.fwd_drive && !s.must_close) begin
        s.fwd_drive = 1'b0;
        s.direction = DIR_BACK;
        s.bwd_drive = 1'b1;
      end
      if (ev.overtorque_seen) begin
        s.must_close = 1'b0;
        if (s.direction == DIR_FORWARD) begin
          if (ev.opened_sensor) begin
            s.fwd_drive = 1'b0;
            s.bwd_drive = 1'b0;
          end else if (ev.running_sensor) begin
            s.fwd_drive = 1'b0;
            s.bwd_drive = 1'b0;
            r.rollback_pulse = 1'b1;
            s.direction = DIR_BACK;
          end
        end else begin
          s.fwd_drive = 1'b0;
          s.bwd_drive = 1'b0;
          s.direction = DIR_FORWARD;
        end
        s.torque_flag = 1'b1;
      end
      if (ev.closed_sensor && ev.opened_sensor) begin
        s.fwd_drive = 1'b0;
        s.bwd_drive = 1'b0;
      end else if (ev.closed_sensor) begin
        s.fwd_drive = 1'b0;
        s.direction = DIR_BACK;
        s.must_close = 1'b1;
        r.restart_idle_timer = 1'b1;
      end else if (ev.opened_sensor) begin
        s.bwd_drive = 1'b0;
        s.direction = DIR_FORWARD;
      end else if (s.direction == DIR_BACK && s.must_close && !s.bwd_drive) begin
        // gate pushed off the closed stop by hand: close it again
        s.power_on = 1'b1;
        s.fwd_drive = 1'b1;
        s.direction = DIR_FORWARD;
      end
    end
    r.drive_forward = s.fwd_drive;
    r.drive_backward = s.bwd_drive;
    r.motor_power = s.power_on;
    r.overtorque_latched = s.torque_flag;
    r.heading = s.direction;
    nxt = s;
    return r;
  endfunction

  task automatic check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    results_owed = 0;
    gate_st = STATE_RESET;
  end

  always @(posedge clk) begin
    gmc_result_t want;
    gmc_result_t got;
    gmc_state_t  nxt;
    if (!rst_n) begin
      gate_st = STATE_RESET;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = gmc_result_t'(out_tdata[$bits(gmc_result_t)-1:0]);
        if (pending_results.size() == 0) begin
          $error("result transfer 0x%0h with no event outstanding", out_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_bit("drive_forward", want.drive_forward, got.drive_forward);
          check_bit("drive_backward", want.drive_backward, got.drive_backward);
          check_bit("motor_power", want.motor_power, got.motor_power);
          check_bit("overtorque_latched", want.overtorque_latched, got.overtorque_latched);
          check_bit("rollback_pulse", want.rollback_pulse, got.rollback_pulse);
          check_bit("restart_idle_timer", want.restart_idle_timer, got.restart_idle_timer);
          check_bit("heading", want.heading, got.heading);
        end
      end
      if (in_tvalid && in_tready) begin
        want = gate_next(gmc_event_t'({in_tdata[$bits(gmc_event_t)-2:0], in_tuser[0]}),
                         gate_st, nxt);
        gate_st = nxt;
        pending_results.push_back(want);
      end
    end
    results_owed = pending_results.size();
  end

endmodule

[verif/tb_gate_motor_controller_core.sv]
module tb_gate_motor_controller_core;
  import gmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Stop the run when neither channel moves a transfer for this many cycles.
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned EventTarget = 1350;

  // Sensor levels for the directed events
  localparam logic Lo = 1'b0;
  localparam logic Hi = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [InTdataW-1:0]  in_tdata = '0;
  logic [InTuserW-1:0]  in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutTdataW-1:0] out_tdata;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned quiet_cycles = 0;
  int unsigned events_sent = 0;
  int unsigned sink_hold = 0;
  bit          src_gaps_on = 1'b1;
  bit          sink_stalls_on = 1'b1;

  gate_motor_controller_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gate_motor_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("gate_motor_controller_core verification failed");
        $finish;
      end
    end
  end

  // Result sink: mostly ready, with short stalls and an occasional long one.
  // Hold ready high throughout while stalls are switched off.
  always @(negedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (rst_n && sink_stalls_on && $urandom_range(0, 99) < 25) begin
      sink_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(5, 39);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic gmc_event_t make_event(input logic op, input logic closed_s,
                                            input logic opened_s, input logic beam,
                                            input logic torque, input logic running);
    gmc_event_t ev;
    ev.opcode = op;
    ev.closed_sensor = closed_s;
    ev.opened_sensor = opened_s;
    ev.beam_blocked = beam;
    ev.overtorque_seen = torque;
    ev.running_sensor = running;
    return ev;
  endfunction

  // Present one event at the falling edge and hold it until the transfer.
  task automatic send_event(input gmc_event_t ev);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= ev.opcode;
    in_tdata <= InTdataW'(ev[$bits(gmc_event_t)-1:1]);
    do @(posedge clk); while (!in_tready);
    events_sent++;
  endtask

  // Drop valid for a random gap: usually none or short, now and then long.
  task automatic source_gap();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (!src_gaps_on || pick < 55) return;
    len = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    repeat (len) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic send_and_gap(input gmc_event_t ev);
    send_event(ev);
    source_gap();
  endtask

  // A full run of the gate: button press, a few port changes while moving,
  // then an end-stop hit. Beam breaks and overtorque show up now and then.
  task automatic gate_travel();
    int unsigned steps;
    int unsigned stop_pick;
    logic at_closed;
    at_closed = ($urandom_range(0, 1) == 1);
    send_and_gap(make_event(OP_BUTTON, at_closed, ~at_closed & ($urandom_range(0, 3) == 0),
                            $urandom_range(0, 99) < 15, 1'b0, ($urandom_range(0, 1) == 1)));
    steps = $urandom_range(1, 4);
    repeat (steps) begin
      send_and_gap(make_event(OP_PORT, 1'b0, 1'b0, $urandom_range(0, 99) < 12,
                              $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 85));
    end
    stop_pick = $urandom_range(0, 99);
    send_and_gap(make_event(OP_PORT, stop_pick < 50 || stop_pick >= 97, stop_pick >= 50,
                            $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 8,
                            ($urandom_range(0, 1) == 1)));
    // Sometimes push the gate off the closed stop by hand.
    if ($urandom_range(0, 3) == 0) begin
      send_and_gap(make_event(OP_PORT, 1'b0, 1'b0, ($urandom_range(0, 1) == 1), 1'b0,
                              ($urandom_range(0, 1) == 1)));
    end
  endtask

  initial begin
    gmc_event_t directed[$];
    int unsigned phase_mark;

    // Hold reset, then release at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk from reset through most branches of the controller.
    directed.push_back(make_event(OP_BUTTON, Lo, Lo, Lo, Lo, Lo)); // start closing
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Hi, Lo, Hi)); // beam break while closing
    directed.push_back(make_event(OP_PORT,   Lo, Hi, Lo, Lo, Lo)); // opened stop reached
    directed.push_back(make_event(OP_BUTTON, Lo, Hi, Hi, Lo, Lo)); // close refused, beam blocked
    directed.push_back(make_event(OP_BUTTON, Lo, Hi, Lo, Lo, Lo)); // close from opened stop
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Lo, Hi, Hi)); // overtorque closing: rollback
    directed.push_back(make_event(OP_PORT,   Hi, Lo, Lo, Lo, Lo)); // closed stop, latch closed
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Lo, Lo, Hi)); // pushed open: forced re-close
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Hi, Lo, Hi)); // beam ignored on re-close
    directed.push_back(make_event(OP_BUTTON, Lo, Lo, Lo, Lo, Hi)); // stop a moving gate, reverse
    directed.push_back(make_event(OP_BUTTON, Lo, Lo, Lo, Lo, Lo)); // start opening
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Lo, Hi, Hi)); // overtorque while opening
    directed.push_back(make_event(OP_PORT,   Lo, Hi, Lo, Hi, Lo)); // overtorque at opened stop
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Lo, Hi, Lo)); // overtorque, not running
    directed.push_back(make_event(OP_BUTTON, Hi, Hi, Lo, Lo, Lo)); // both stops on a button
    directed.push_back(make_event(OP_PORT,   Hi, Hi, Lo, Lo, Lo)); // both stops on a port change
    directed.push_back(make_event(OP_BUTTON, Hi, Lo, Lo, Lo, Lo)); // open from closed stop
    directed.push_back(make_event(OP_BUTTON, Lo, Lo, Hi, Lo, Lo)); // stop while opening
    directed.push_back(make_event(OP_BUTTON, Lo, Hi, Hi, Lo, Lo)); // back at opened stop, beam
    directed.push_back(make_event(OP_BUTTON, Hi, Hi, Hi, Hi, Hi)); // every bit set, button
    directed.push_back(make_event(OP_PORT,   Hi, Hi, Hi, Hi, Hi)); // every bit set, port
    directed.push_back(make_event(OP_PORT,   Lo, Lo, Lo, Lo, Lo)); // quiet port change
    foreach (directed[i]) send_and_gap(directed[i]);

    // Random part: mostly coherent gate runs, the rest uniform noise.
    // Switch gaps and stalls on and off in phases so both calm and busy
    // stretches occur.
    phase_mark = events_sent;
    while (events_sent < EventTarget) begin
      if (events_sent - phase_mark >= 150) begin
        phase_mark = events_sent;
        src_gaps_on = ($urandom_range(0, 3) != 0);
        sink_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 75) begin
        gate_travel();
      end else begin
        send_and_gap(gmc_event_t'($urandom_range(0, 2 ** $bits(gmc_event_t) - 1)));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    sink_stalls_on = 1'b1;

    // Drain the outstanding results, then allow the pipeline to settle.
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("gate_motor_controller_core verification clean");
    end else begin
      $display("gate_motor_controller_core verification failed");
    end
    $finish;
  end

endmodule
